[src/rgbpwe_pkg.sv]
// Shared types, codes and helpers for the RGB LED pulse-width encoder.
package rgbpwe_pkg;

  localparam int COLOR_BITS_DEF = 24;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int PULSE_W        = 8;
  localparam int COUNT_W        = 16;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_SEND  = 2'd1;
  localparam logic [1:0] CMD_LATCH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LATCH     = 3'd4;

  localparam logic [PULSE_W-1:0] ZERO_HIGH_RST = 8'd7;
  localparam logic [PULSE_W-1:0] ZERO_LOW_RST  = 8'd16;
  localparam logic [PULSE_W-1:0] ONE_HIGH_RST  = 8'd14;
  localparam logic [PULSE_W-1:0] ONE_LOW_RST   = 8'd12;
  localparam logic [COUNT_W-1:0] LATCH_RST     = 16'd10000;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2,
    PH_LATCH = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [23:0] color_word;
    logic        row;
  } in_word_t;

  typedef struct packed {
    logic middle_pin;
    logic side_pin;
    logic busy_res;
    logic done_res;
    logic rejected;
  } out_word_t;

  // A programmed length of zero still lasts one tick.
  function automatic logic [COUNT_W-1:0] min_one(input logic [COUNT_W-1:0] v);
    min_one = (v == '0) ? COUNT_W'(1) : v;
  endfunction

endpackage

[src/rgb_led_pulse_width_encoder_unit.sv]
// Top level of the RGB LED pulse-width encoder: tick sequencer and result register.
// The result word of an accepted input word shows in the output register in the cycle after its acceptance.
// Throughput: one word per cycle while in_stall is low; the tick sequencer updates its state in the accept cycle.
// Input stall rises only while the output register holds a word that is being stalled.
// Reset (synchronous, rst_n low): sequencer idle, result register empty,
// pulse and latch lengths back to their defaults (7, 16, 14, 12, 10000 ticks).
module rgb_led_pulse_width_encoder_unit
  import rgbpwe_pkg::*;
#(
  parameter int COLOR_BITS = COLOR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int BIT_W = $clog2(COLOR_BITS);
  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(COLOR_BITS - 1);

  // Timing registers
  logic [PULSE_W-1:0] zero_high_r, zero_low_r, one_high_r, one_low_r;
  logic [COUNT_W-1:0] latch_r;

  // Sequencer state
  phase_t              phase_r, phase_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [COLOR_BITS-1:0] shift_word_r, shift_word_nxt;
  logic [BIT_W-1:0]    bits_left_r, bits_left_nxt;
  logic                row_r, row_nxt;

  // Result register
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r, out_word_nxt;

  // State after this tick's command has been applied
  phase_t                phase_a;
  logic [COUNT_W-1:0]    count_a, count_dec;
  logic [COLOR_BITS-1:0] word_a;
  logic [BIT_W-1:0]      bits_left_a;
  logic                  row_a;
  logic                  rejected_a;
  logic                  in_accept;
  logic                  level;

  // Accept a new word whenever the result register is free or being drained.
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign cfg_ready = 1'b1;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_high_r <= ZERO_HIGH_RST;
      zero_low_r  <= ZERO_LOW_RST;
      one_high_r  <= ONE_HIGH_RST;
      one_low_r   <= ONE_LOW_RST;
      latch_r     <= LATCH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ZERO_HIGH: zero_high_r <= cfg_data[PULSE_W-1:0];
        CFG_ZERO_LOW:  zero_low_r  <= cfg_data[PULSE_W-1:0];
        CFG_ONE_HIGH:  one_high_r  <= cfg_data[PULSE_W-1:0];
        CFG_ONE_LOW:   one_low_r   <= cfg_data[PULSE_W-1:0];
        CFG_LATCH:     latch_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Command decode: a send or latch starts only from idle, otherwise it is rejected.
  // A started word or latch shows on this same tick's result.
  always_comb begin
    phase_a     = phase_r;
    count_a     = count_r;
    word_a      = shift_word_r;
    bits_left_a = bits_left_r;
    row_a       = row_r;
    rejected_a  = 1'b0;
    if (in_word.command == CMD_SEND || in_word.command == CMD_LATCH) begin
      if (phase_r != PH_IDLE) begin
        rejected_a = 1'b1;
      end else if (in_word.command == CMD_SEND) begin
        // Bits of the color word above COLOR_BITS are dropped here.
        word_a      = COLOR_BITS'(in_word.color_word);
        bits_left_a = BIT_LAST;
        row_a       = in_word.row;
        phase_a     = PH_HIGH;
        count_a     = min_one(COUNT_W'(word_a[BIT_LAST] ? one_high_r : zero_high_r));
      end else begin
        row_a   = in_word.row;
        phase_a = PH_LATCH;
        count_a = min_one(latch_r);
      end
    end
  end

  // Result of this tick: pin levels, busy, done, rejected.
  always_comb begin
    level                   = (phase_a == PH_HIGH);
    out_word_nxt.middle_pin = level & ~row_a;
    out_word_nxt.side_pin   = level & row_a;
    out_word_nxt.busy_res   = (phase_a != PH_IDLE);
    out_word_nxt.done_res   = (count_a == COUNT_W'(1)) &&
                              (phase_a == PH_LATCH ||
                               (phase_a == PH_LOW && bits_left_a == '0));
    out_word_nxt.rejected   = rejected_a;
  end

  // Next state: count the tick down, then advance the phase when the count expires.
  always_comb begin
    count_dec      = (count_a != '0) ? count_a - COUNT_W'(1) : count_a;
    phase_nxt      = phase_a;
    count_nxt      = count_a;
    shift_word_nxt = word_a;
    bits_left_nxt  = bits_left_a;
    row_nxt        = row_a;
    if (phase_a != PH_IDLE) begin
      count_nxt = count_dec;
      if (count_dec == '0) begin
        case (phase_a)
          PH_HIGH: begin
            phase_nxt = PH_LOW;
            count_nxt = min_one(COUNT_W'(word_a[bits_left_a] ? one_low_r : zero_low_r));
          end
          PH_LOW: begin
            if (bits_left_a != '0) begin
              bits_left_nxt = bits_left_a - BIT_W'(1);
              phase_nxt     = PH_HIGH;
              count_nxt     = min_one(COUNT_W'(word_a[bits_left_a - BIT_W'(1)] ?
                                               one_high_r : zero_high_r));
            end else begin
              phase_nxt     = PH_IDLE;
              bits_left_nxt = '0;
            end
          end
          default: begin
            phase_nxt     = PH_IDLE;
            bits_left_nxt = '0;
          end
        endcase
      end
    end
  end

  // Hold the result word until taken; load a new one on every accepted tick.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      count_r      <= '0;
      shift_word_r <= '0;
      bits_left_r  <= '0;
      row_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        phase_r      <= phase_nxt;
        count_r      <= count_nxt;
        shift_word_r <= shift_word_nxt;
        bits_left_r  <= bits_left_nxt;
        row_r        <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_word_r <= out_word_nxt;
    end
  end

endmodule

[verif/rgb_led_pulse_width_encoder_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the RGB LED pulse-width encoder top level.
module rgb_led_pulse_width_encoder_unit_tb;
  import rgbpwe_pkg::*;

  // Command code 3 has no name in the package; the block treats it as a plain tick.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // Register index that maps to no register; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;
  // Cycles with no handshake on any channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 5000;
  // Length of the forced receiver hold-off.
  localparam int LONG_HOLD = 400;

  // Tick predictor and store of expected pin words.
  class led_tick_scoreboard;
    logic [PULSE_W-1:0] zero_hi, zero_lo, one_hi, one_lo;
    logic [COUNT_W-1:0] latch_len;
    logic [23:0]        shreg;
    logic [4:0]         bit_idx;
    phase_t             ph;
    logic [COUNT_W-1:0] ticks_left;
    logic               row_q;
    out_word_t          pin_words_q[$];
    int                 errors;

    function new();
      zero_hi    = ZERO_HIGH_RST;
      zero_lo    = ZERO_LOW_RST;
      one_hi     = ONE_HIGH_RST;
      one_lo     = ONE_LOW_RST;
      latch_len  = LATCH_RST;
      shreg      = '0;
      bit_idx    = '0;
      ph         = PH_IDLE;
      ticks_left = '0;
      row_q      = 1'b0;
      errors     = 0;
    endfunction

    function automatic logic [COUNT_W-1:0] stretch_len(input logic [COUNT_W-1:0] v);
      return (v == '0) ? COUNT_W'(1) : v;
    endfunction

    function automatic logic [COUNT_W-1:0] pulse_len(input bit high_part);
      logic [PULSE_W-1:0] raw;
      if (shreg[bit_idx])
        raw = high_part ? one_hi : one_lo;
      else
        raw = high_part ? zero_hi : zero_lo;
      return stretch_len(COUNT_W'(raw));
    endfunction

    function void note_config(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ZERO_HIGH: zero_hi = data[PULSE_W-1:0];
        CFG_ZERO_LOW:  zero_lo = data[PULSE_W-1:0];
        CFG_ONE_HIGH:  one_hi = data[PULSE_W-1:0];
        CFG_ONE_LOW:   one_lo = data[PULSE_W-1:0];
        CFG_LATCH:     latch_len = data[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    // Advance one tick and queue the pin word it must produce.
    function void note_input(input in_word_t w);
      out_word_t r;
      logic      level;
      r = '0;
      if (w.command == CMD_SEND || w.command == CMD_LATCH) begin
        if (ph != PH_IDLE) begin
          r.rejected = 1'b1;
        end else if (w.command == CMD_SEND) begin
          shreg      = w.color_word;
          bit_idx    = 5'(COLOR_BITS_DEF - 1);
          row_q      = w.row;
          ph         = PH_HIGH;
          ticks_left = pulse_len(1'b1);
        end else begin
          row_q      = w.row;
          ph         = PH_LATCH;
          ticks_left = stretch_len(latch_len);
        end
      end
      level        = (ph == PH_HIGH);
      r.middle_pin = level && !row_q;
      r.side_pin   = level && row_q;
      r.busy_res   = (ph != PH_IDLE);
      r.done_res   = (ticks_left == 1) &&
                     (ph == PH_LATCH || (ph == PH_LOW && bit_idx == 0));
      pin_words_q.push_back(r);
      // Count the tick down and step to the next pulse when it runs out.
      if (ph != PH_IDLE) begin
        if (ticks_left > 0) ticks_left--;
        if (ticks_left == 0) begin
          if (ph == PH_HIGH) begin
            ph         = PH_LOW;
            ticks_left = pulse_len(1'b0);
          end else if (ph == PH_LOW && bit_idx != 0) begin
            bit_idx--;
            ph         = PH_HIGH;
            ticks_left = pulse_len(1'b1);
          end else begin
            ph      = PH_IDLE;
            bit_idx = '0;
          end
        end
      end
    endfunction

    function int pending();
      return pin_words_q.size();
    endfunction

    function bit is_idle();
      return ph == PH_IDLE;
    endfunction

    task report_mismatch(input string msg);
      if (errors < 100) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task compare_pin(input string name, input logic got, input logic want);
      if (got !== want) report_mismatch($sformatf("%s got %b want %b", name, got, want));
    endtask

    task check_result(input out_word_t got);
      out_word_t want;
      if (pin_words_q.size() == 0) begin
        report_mismatch($sformatf("pin word %b arrived with nothing expected", got));
        return;
      end
      want = pin_words_q.pop_front();
      compare_pin("middle_pin", got.middle_pin, want.middle_pin);
      compare_pin("side_pin", got.side_pin, want.side_pin);
      compare_pin("busy_res", got.busy_res, want.busy_res);
      compare_pin("done_res", got.done_res, want.done_res);
      compare_pin("rejected", got.rejected, want.rejected);
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_word;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_word;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  led_tick_scoreboard sb;
  bit offering;      // in_valid as last driven
  int burst_left;    // words left in the current sender burst
  bit hold_request;  // ask the receiver for one long hold-off

  rgb_led_pulse_width_encoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check every accepted pin word against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_word);
  end

  // Abort when no channel moves a word for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no handshake for %0d cycles", $time, quiet);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Receiver: stall on a changing pattern, plus one long hold-off on request.
  initial begin : receiver
    int hold_left;
    int mode;
    int mode_left;
    int phase_cnt;
    hold_left = 0;
    mode      = 0;
    mode_left = 0;
    phase_cnt = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      phase_cnt++;
      if (hold_request && hold_left == 0) begin
        hold_left    = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        // Hold off so the output register fills and the input stalls.
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= (phase_cnt % 7 < 3);
        endcase
      end
    end
  end

  function automatic in_word_t make_word(input logic [1:0] cmd, input logic [23:0] color,
                                         input logic row);
    in_word_t w;
    w.command    = cmd;
    w.color_word = color;
    w.row        = row;
    return w;
  endfunction

  // Tick offered while a word or latch runs; now and then a random command, which bounces if it is a send or latch.
  function automatic in_word_t busy_tick();
    logic [1:0] cmd;
    cmd = ($urandom_range(0, 11) == 0) ? 2'($urandom_range(0, 3)) : CMD_TICK;
    return make_word(cmd, 24'($urandom), 1'($urandom));
  endfunction

  // Offer one word and hold it until accepted; open a new burst with a gap when due.
  task automatic push_word(input in_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        if (offering) in_valid <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_word  <= w;
    in_valid <= 1'b1;
    offering = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_input(w);
  endtask

  task automatic stop_sending();
    if (offering) in_valid <= 1'b0;
    offering   = 1'b0;
    burst_left = 0;
  endtask

  // Tick until the predicted sequencer is idle again.
  task automatic run_out();
    while (!sb.is_idle()) push_word(busy_tick());
  endtask

  // Pause the sender until every expected word is back, then let the block settle.
  task automatic settle();
    stop_sending();
    while (sb.pending() > 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_lengths(input logic [CFG_DATA_W-1:0] zh, input logic [CFG_DATA_W-1:0] zl,
                                 input logic [CFG_DATA_W-1:0] oh, input logic [CFG_DATA_W-1:0] ol,
                                 input logic [CFG_DATA_W-1:0] lt);
    write_reg(CFG_ZERO_HIGH, zh);
    write_reg(CFG_ZERO_LOW, zl);
    write_reg(CFG_ONE_HIGH, oh);
    write_reg(CFG_ONE_LOW, ol);
    write_reg(CFG_LATCH, lt);
  endtask

  // Pulse length for a random setting: mostly very short, sometimes a few ticks more,
  // junk above bit 7.
  function automatic logic [CFG_DATA_W-1:0] rand_pulse();
    logic [7:0] len;
    len = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(4, 9)) : 8'($urandom_range(0, 3));
    return {8'($urandom), len};
  endfunction

  initial begin : main
    int sent;
    int pick;
    sb           = new();
    offering     = 1'b0;
    burst_left   = 0;
    hold_request = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_word   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Idle ticks right after reset, including the unused command.
    push_word(make_word(CMD_TICK, 24'h000000, 1'b0));
    push_word(make_word(CMD_UNUSED, 24'hFFFFFF, 1'b1));
    settle();

    // Short lengths: an all-ones word, commands that arrive while busy,
    // and a latch on the side row.
    program_lengths(16'h0001, 16'h0002, 16'h0002, 16'h0001, 16'h0040);
    push_word(make_word(CMD_SEND, 24'hFFFFFF, 1'b0));
    push_word(make_word(CMD_SEND, 24'h123456, 1'b1));
    push_word(make_word(CMD_LATCH, 24'h000000, 1'b1));
    push_word(make_word(CMD_UNUSED, 24'h000000, 1'b0));
    run_out();
    push_word(make_word(CMD_LATCH, 24'hFFFFFF, 1'b1));
    run_out();
    settle();

    // Zero lengths: every pulse and the latch collapse to one tick.
    program_lengths(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    push_word(make_word(CMD_SEND, 24'h000000, 1'b1));
    run_out();
    push_word(make_word(CMD_SEND, 24'hA5A5A5, 1'b0));
    run_out();
    push_word(make_word(CMD_LATCH, 24'h5A5A5A, 1'b1));
    run_out();
    push_word(make_word(CMD_LATCH, 24'h000000, 1'b0));
    run_out();
    settle();

    // Junk in the upper data byte; the pulse registers must drop it.
    program_lengths(16'hFF01, 16'hC302, 16'h8001, 16'h7F03, 16'h0010);
    write_reg(CFG_NONE, 16'($urandom));
    push_word(make_word(CMD_SEND, 24'h800001, 1'b1));
    run_out();
    push_word(make_word(CMD_LATCH, 24'h000000, 1'b0));
    run_out();

    // Random rounds: mostly complete words and latches with random content,
    // the rest loose commands; the second round runs into the long receiver hold-off.
    for (int round_i = 0; round_i < 3; round_i++) begin
      settle();
      if (round_i == 0)
        program_lengths(16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001);
      else
        program_lengths(rand_pulse(), rand_pulse(), rand_pulse(), rand_pulse(),
                        ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 120))
                                                    : 16'($urandom_range(0, 20)));
      if (round_i == 1) hold_request = 1'b1;
      sent = 0;
      while (sent < 40) begin
        pick = $urandom_range(0, 9);
        if (pick < 5)
          push_word(make_word(CMD_SEND, 24'($urandom), 1'($urandom)));
        else if (pick < 7)
          push_word(make_word(CMD_LATCH, 24'($urandom), 1'($urandom)));
        else
          push_word(make_word(2'($urandom_range(0, 3)), 24'($urandom), 1'($urandom)));
        sent++;
        while (!sb.is_idle()) begin
          push_word(busy_tick());
          sent++;
        end
      end
    end

    // Drain: wait for every expected word, then keep watching for strays before the final check.
    stop_sending();
    while (sb.pending() > 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (sb.pending() > 0)
      sb.report_mismatch($sformatf("%0d expected words never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
